// ===== sv/espl_pkg.sv =====
// ----------------------------------------------------------------------------
// Encoder PID speed loop: shared types and constants
// Field widths, datapath widths, step codes and register reset values.
// ----------------------------------------------------------------------------
package espl_pkg;

   // field widths
   localparam int CNT_W  = 16;   // encoder counter and count delta
   localparam int TGT_W  = 13;   // speed target
   localparam int SPD_W  = 24;   // measured speed, speed gap
   localparam int DUTY_W = 13;   // PWM duty
   localparam int GAIN_W = 16;
   localparam int MULT_W = 8;

   // stream widths
   localparam int IN_W  = 32;
   localparam int OUT_W = 80;

   // internal widths
   localparam int ERR_W  = 25;   // control error
   localparam int DERR_W = 26;   // error difference
   localparam int INT_W  = 27;   // integral in milli error units
   localparam int INTS_W = 28;   // integral plus error before clamp
   localparam int LIM_W  = 26;   // integral_limit * 1000
   localparam int MA_W   = 27;   // multiplier operand a, signed
   localparam int MB_W   = 25;   // multiplier operand b, signed
   localparam int PROD_W = MA_W + MB_W;
   localparam int PD_W   = 43;   // Kp*err + Kd*derr
   localparam int ACC_W  = 54;   // full PID accumulator
   localparam int X_W    = 23;   // |acc| / 256 below the saturation point

   localparam int SPD_SHIFT   = 8;
   localparam int DIV_SHIFT   = 8;
   localparam int RECIP_SHIFT = 33;

   localparam logic signed [TGT_W-1:0] TARGET_MAX = 13'sd3000;
   localparam logic signed [TGT_W-1:0] TARGET_MIN = -13'sd3000;
   localparam logic [DUTY_W-1:0]       PWM_TOP    = 13'd4199;
   // (PWM_TOP + 1) * 256 * 1000: any magnitude at or above saturates the duty
   localparam logic [ACC_W-1:0]        DUTY_SAT_MAG = 54'd1075200000;
   // ceil(2^33 / 1000): exact floor division for quotients below 2^23
   localparam logic signed [MB_W-1:0]  RECIP_1000 = 25'sd8589935;

   // configuration register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_MULT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_SPEED = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_LIMIT = 3'd5;

   localparam logic [GAIN_W-1:0] RST_PROP_GAIN   = 16'd589;
   localparam logic [GAIN_W-1:0] RST_INTEG_GAIN  = 16'd128;
   localparam logic [GAIN_W-1:0] RST_DERIV_GAIN  = 16'd256;
   localparam logic [MULT_W-1:0] RST_TARGET_MULT = 8'd7;
   localparam logic [GAIN_W-1:0] RST_COUNT_SPEED = 16'd20349;
   localparam logic [GAIN_W-1:0] RST_INTEG_LIMIT = 16'd2000;

   typedef struct packed {
      logic [GAIN_W-1:0] prop_gain_q8;
      logic [GAIN_W-1:0] integ_gain_q8;
      logic [GAIN_W-1:0] deriv_gain_q8;
      logic [MULT_W-1:0] target_multiplier;
      logic [GAIN_W-1:0] count_to_speed_q8;
      logic [GAIN_W-1:0] integral_limit;
   } cfg_type;

   typedef enum logic [3:0] {
      STEP_NONE,
      STEP_LOAD,     // take the sample, form delta and target
      STEP_SPEED,    // multiply delta by count_to_speed
      STEP_TARGET,   // truncate speed toward zero, multiply target by multiplier
      STEP_ERROR,    // form error and gap
      STEP_PROP,     // update integral, multiply Kp by error
      STEP_INTEG,    // multiply Ki by integral
      STEP_DERIV,    // multiply Kd by error difference
      STEP_PD,       // sum proportional and derivative terms
      STEP_ACC,      // scale by 1000 and add integral term
      STEP_SCALE,    // magnitude, saturation, multiply by reciprocal
      STEP_FINISH    // load the result register
   } step_type;

   typedef struct packed {
      step_type step;
   } dp_cmd_type;

   typedef struct packed {
      logic [DUTY_W-1:0]       pwm_duty;
      logic signed [SPD_W-1:0] measured_speed;
      logic signed [CNT_W-1:0] count_delta;
      logic [SPD_W-1:0]        speed_gap;
   } result_type;

endpackage

// ===== sv/espl_ctrl.sv =====
// ----------------------------------------------------------------------------
// Encoder PID speed loop: controller
// Sequences the datapath steps for one sample and owns the result handshake.
// ----------------------------------------------------------------------------
module espl_ctrl import espl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPEED,
      ST_TARGET,
      ST_ERROR,
      ST_PROP,
      ST_INTEG,
      ST_DERIV,
      ST_PD,
      ST_ACC,
      ST_SCALE,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      unique case (state_ff)
         ST_IDLE:   cmd.step = req_tvalid ? STEP_LOAD : STEP_NONE;
         ST_SPEED:  cmd.step = STEP_SPEED;
         ST_TARGET: cmd.step = STEP_TARGET;
         ST_ERROR:  cmd.step = STEP_ERROR;
         ST_PROP:   cmd.step = STEP_PROP;
         ST_INTEG:  cmd.step = STEP_INTEG;
         ST_DERIV:  cmd.step = STEP_DERIV;
         ST_PD:     cmd.step = STEP_PD;
         ST_ACC:    cmd.step = STEP_ACC;
         ST_SCALE:  cmd.step = STEP_SCALE;
         ST_FINISH: cmd.step = out_free ? STEP_FINISH : STEP_NONE;
         default:   cmd.step = STEP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE:   if (req_tvalid) state_ff <= ST_SPEED;
            ST_SPEED:  state_ff <= ST_TARGET;
            ST_TARGET: state_ff <= ST_ERROR;
            ST_ERROR:  state_ff <= ST_PROP;
            ST_PROP:   state_ff <= ST_INTEG;
            ST_INTEG:  state_ff <= ST_DERIV;
            ST_DERIV:  state_ff <= ST_PD;
            ST_PD:     state_ff <= ST_ACC;
            ST_ACC:    state_ff <= ST_SCALE;
            ST_SCALE:  state_ff <= ST_FINISH;
            // hold until the result register is free
            ST_FINISH: if (out_free) state_ff <= ST_IDLE;
            default:   state_ff <= ST_IDLE;
         endcase

         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== sv/espl_dpath.sv =====
// ----------------------------------------------------------------------------
// Encoder PID speed loop: datapath
// Loop state, one shared 27x25 multiplier and the result register.
// ----------------------------------------------------------------------------
module espl_dpath import espl_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  dp_cmd_type              cmd,
   input  logic [CNT_W-1:0]        encoder_count,
   input  logic signed [TGT_W-1:0] speed_target,
   output result_type              result
);

   // loop state
   logic [CNT_W-1:0]        prev_count_ff;
   logic signed [INT_W-1:0] integ_ff;
   logic signed [ERR_W-1:0] prev_err_ff;

   // per-sample working registers
   logic signed [CNT_W-1:0]  delta_ff;
   logic signed [TGT_W-1:0]  target_ff;
   logic                     run_ff;
   logic [LIM_W-1:0]         lim_ff;
   logic signed [SPD_W-1:0]  speed_ff;
   logic signed [ERR_W-1:0]  err_ff;
   logic [SPD_W-1:0]         gap_ff;
   logic signed [DERR_W-1:0] derr_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PD_W-1:0]   pd_ff;
   logic signed [PD_W-1:0]   iterm_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     sat_ff;
   result_type               result_ff;

   // combinational
   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic                     mul_en;
   logic signed [TGT_W-1:0]  target_sat;
   logic [LIM_W-1:0]         lim_calc;
   logic [PROD_W-1:0]        spd_bias;
   logic signed [ERR_W-1:0]  tm_prod;
   logic signed [ERR_W-1:0]  err_calc;
   logic signed [ERR_W-1:0]  gap_diff;
   logic [ERR_W-1:0]         gap_mag;
   logic signed [INTS_W-1:0] integ_sum;
   logic signed [INTS_W-1:0] lim_pos;
   logic signed [INTS_W-1:0] lim_neg;
   logic signed [INTS_W-1:0] integ_clamp;
   logic signed [ACC_W-1:0]  pd_ext;
   logic signed [ACC_W-1:0]  acc_calc;
   logic [ACC_W-1:0]         acc_mag;
   logic [X_W-1:0]           scale_x;
   logic [DUTY_W-1:0]        duty_calc;

   assign target_sat = (speed_target > TARGET_MAX) ? TARGET_MAX :
                       (speed_target < TARGET_MIN) ? TARGET_MIN : speed_target;
   // limit * 1000 = limit * (1024 - 16 - 8)
   assign lim_calc = {cfg.integral_limit, 10'b0}
                   - {6'b0, cfg.integral_limit, 4'b0}
                   - {7'b0, cfg.integral_limit, 3'b0};

   // truncate toward zero: bias negative products before the shift
   assign spd_bias = prod_ff + {{(PROD_W-SPD_SHIFT){1'b0}}, {SPD_SHIFT{prod_ff[PROD_W-1]}}};

   assign tm_prod  = prod_ff[ERR_W-1:0];
   assign err_calc = tm_prod - ERR_W'(speed_ff);
   assign gap_diff = ERR_W'(target_ff) - ERR_W'(speed_ff);
   assign gap_mag  = gap_diff[ERR_W-1] ? ERR_W'(-gap_diff) : gap_diff;

   assign integ_sum   = INTS_W'(integ_ff) + INTS_W'(err_ff);
   assign lim_pos     = $signed({{(INTS_W-LIM_W){1'b0}}, lim_ff});
   assign lim_neg     = -lim_pos;
   assign integ_clamp = (integ_sum > lim_pos) ? lim_pos :
                        (integ_sum < lim_neg) ? lim_neg : integ_sum;

   assign pd_ext   = ACC_W'(pd_ff);
   assign acc_calc = (pd_ext <<< 10) - (pd_ext <<< 4) - (pd_ext <<< 3) + ACC_W'(iterm_ff);
   assign acc_mag  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : acc_ff;
   assign scale_x  = acc_mag[X_W+DIV_SHIFT-1:DIV_SHIFT];

   assign duty_calc = !run_ff ? '0 :
                      sat_ff  ? PWM_TOP : prod_ff[RECIP_SHIFT+DUTY_W-1:RECIP_SHIFT];

   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      case (cmd.step)
         STEP_SPEED: begin
            mul_a = MA_W'(delta_ff);
            mul_b = $signed(MB_W'(cfg.count_to_speed_q8));
         end
         STEP_TARGET: begin
            mul_a = MA_W'(target_ff);
            mul_b = $signed(MB_W'(cfg.target_multiplier));
         end
         STEP_PROP: begin
            mul_a = MA_W'(err_ff);
            mul_b = $signed(MB_W'(cfg.prop_gain_q8));
         end
         STEP_INTEG: begin
            mul_a = integ_ff;
            mul_b = $signed(MB_W'(cfg.integ_gain_q8));
         end
         STEP_DERIV: begin
            mul_a = MA_W'(derr_ff);
            mul_b = $signed(MB_W'(cfg.deriv_gain_q8));
         end
         STEP_SCALE: begin
            mul_a = $signed(MA_W'(scale_x));
            mul_b = RECIP_1000;
         end
         default: mul_en = 1'b0;
      endcase
   end

   // loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_count_ff <= '0;
         integ_ff      <= '0;
         prev_err_ff   <= '0;
      end else begin
         if (cmd.step == STEP_LOAD) begin
            prev_count_ff <= encoder_count;
         end
         if (cmd.step == STEP_PROP) begin
            if (run_ff) begin
               integ_ff    <= integ_clamp[INT_W-1:0];
               prev_err_ff <= err_ff;
            end else begin
               integ_ff    <= '0;
               prev_err_ff <= '0;
            end
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      case (cmd.step)
         STEP_LOAD: begin
            delta_ff  <= $signed(encoder_count - prev_count_ff);
            target_ff <= target_sat;
            run_ff    <= (speed_target != '0);
            lim_ff    <= lim_calc;
         end
         STEP_TARGET: speed_ff <= $signed(spd_bias[SPD_W+SPD_SHIFT-1:SPD_SHIFT]);
         STEP_ERROR: begin
            err_ff <= err_calc;
            gap_ff <= run_ff ? gap_mag[SPD_W-1:0] : '0;
         end
         STEP_PROP:  derr_ff  <= DERR_W'(err_ff) - DERR_W'(prev_err_ff);
         STEP_INTEG: pd_ff    <= prod_ff[PD_W-1:0];
         STEP_DERIV: iterm_ff <= prod_ff[PD_W-1:0];
         STEP_PD:    pd_ff    <= pd_ff + $signed(prod_ff[PD_W-1:0]);
         STEP_ACC:   acc_ff   <= acc_calc;
         STEP_SCALE: sat_ff   <= (acc_mag >= DUTY_SAT_MAG);
         STEP_FINISH: begin
            result_ff.pwm_duty       <= duty_calc;
            result_ff.measured_speed <= speed_ff;
            result_ff.count_delta    <= delta_ff;
            result_ff.speed_gap      <= gap_ff;
         end
         default: ;
      endcase
   end

   assign result = result_ff;

endmodule

// ===== sv/encoder_pid_speed_loop.sv =====
// ----------------------------------------------------------------------------
// Encoder PID speed loop
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// One transfer on req_ is one control tick: the encoder counter sample and the
// speed target. The block answers with exactly one transfer on rsp_ carrying
// the PWM duty, the measured speed, the count delta and the speed gap. An item
// is taken only while the block is idle; the controller then steps through the
// speed, target, error, prop, integ, deriv, PD, acc, scale and finish states,
// loads the result once the output register is free and returns to idle. The
// pace is set by the single shared 27x25 multiplier, which is used six times in
// sequence per item (speed scaling, target scaling, the three PID gains and the
// divide by 1000). The result sits in an output register, so a new item is
// accepted while the previous result still waits to be taken. Write
// configuration registers only while no item is in flight.
module encoder_pid_speed_loop import espl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: encoder_count[15:0], speed_target[28:16], zero pad
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [IN_W-1:0]       req_tdata,
   // rsp_tdata: pwm_duty[12:0], measured_speed[36:13], count_delta[52:37],
   //            speed_gap[76:53], zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_W-1:0]      rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg_ff;
   dp_cmd_type cmd;
   result_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain_q8      <= RST_PROP_GAIN;
         cfg_ff.integ_gain_q8     <= RST_INTEG_GAIN;
         cfg_ff.deriv_gain_q8     <= RST_DERIV_GAIN;
         cfg_ff.target_multiplier <= RST_TARGET_MULT;
         cfg_ff.count_to_speed_q8 <= RST_COUNT_SPEED;
         cfg_ff.integral_limit    <= RST_INTEG_LIMIT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PROP_GAIN:   cfg_ff.prop_gain_q8      <= csr_wdata;
            CSR_INTEG_GAIN:  cfg_ff.integ_gain_q8     <= csr_wdata;
            CSR_DERIV_GAIN:  cfg_ff.deriv_gain_q8     <= csr_wdata;
            CSR_TARGET_MULT: cfg_ff.target_multiplier <= csr_wdata[MULT_W-1:0];
            CSR_COUNT_SPEED: cfg_ff.count_to_speed_q8 <= csr_wdata;
            CSR_INTEG_LIMIT: cfg_ff.integral_limit    <= csr_wdata;
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   espl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   espl_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .cmd           (cmd),
      .encoder_count (req_tdata[CNT_W-1:0]),
      .speed_target  ($signed(req_tdata[CNT_W+TGT_W-1:CNT_W])),
      .result        (result)
   );

   assign rsp_tdata = {{(OUT_W-DUTY_W-2*SPD_W-CNT_W){1'b0}},
                       result.speed_gap,
                       result.count_delta,
                       result.measured_speed,
                       result.pwm_duty};

endmodule
